// ----- rtl/fpl_pkg.sv -----
// fpl_pkg: shared widths, codes, status structs and sequencer states for the
// four-pole ladder low-pass core. No dependencies; every other file uses it.

package fpl_pkg;

  // Word and register widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned P_W       = 15;
  localparam int unsigned K_W       = 16;
  localparam int unsigned R_W       = 17;
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;

  // Filter state is Q4.20
  localparam int unsigned STATE_W = 24;

  // Serial multiplier: multiplier shift register, short pass length,
  // multiplicand and accumulator widths
  localparam int unsigned MPLR_W    = 24;
  localparam int unsigned COEF_BITS = 18;
  localparam int unsigned MCAND_W   = 28;
  localparam int unsigned ACC_W     = 52;
  localparam int unsigned CNT_W     = 5;

  // Clipper: square and cube widths, divider count and remainder widths, and the constant divisor
  localparam int unsigned SQ_W     = 28;
  localparam int unsigned CUBE_W   = 31;
  localparam int unsigned DIV_CNT_W = 5;
  localparam int unsigned REM_W    = 3;
  localparam logic [REM_W:0] CLIP_DIVISOR = 4'd6;

  // Reset values of the coefficient registers
  localparam logic [P_W-1:0]        COEF_P_RST  = 15'd583;
  localparam logic signed [K_W-1:0] COEF_K_RST  = -16'sd15218;
  localparam logic [R_W-1:0]        FB_GAIN_RST = 17'd31190;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_P  = 2'd0,
    CFG_COEF_K  = 2'd1,
    CFG_FB_GAIN = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic start;
    logic narrow;  // short pass over COEF_BITS multiplier bits
  } mac_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FEED_GO,
    ST_FEED_RUN,
    ST_STG_GO,
    ST_STG_RUN,
    ST_SQ_GO,
    ST_SQ_RUN,
    ST_CUBE_GO,
    ST_CUBE_RUN,
    ST_DIV_GO,
    ST_DIV_RUN,
    ST_FINISH
  } seq_state_e;

endpackage

// ----- rtl/fpl_if.sv -----
// fpl_if: valid/ready channels carrying input and output sample words.
// Depends on fpl_pkg for the sample width.

interface fpl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fpl_pkg::SAMPLE_W-1:0]  sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fpl_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fpl_pkg::SAMPLE_W-1:0]  sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- rtl/fpl_mac.sv -----
// fpl_mac: bit-serial signed multiply-accumulate, a*x - b*y, MSB first.
// Depends on fpl_pkg for widths and the command/status structs.

module fpl_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  fpl_pkg::mac_cmd_t                     cmd_i,
  input  logic signed [fpl_pkg::MPLR_W-1:0]     mplr_a_i,
  input  logic signed [fpl_pkg::MCAND_W-1:0]    mcand_a_i,
  input  logic signed [fpl_pkg::MPLR_W-1:0]     mplr_b_i,
  input  logic signed [fpl_pkg::MCAND_W-1:0]    mcand_b_i,
  output fpl_pkg::unit_stat_t                   stat_o,
  output logic signed [fpl_pkg::ACC_W-1:0]      prod_o
);

  localparam int unsigned PadW = fpl_pkg::MPLR_W - fpl_pkg::COEF_BITS;

  logic                                busy_q, done_q, first_q;
  logic [fpl_pkg::CNT_W-1:0]           cnt_q;
  logic [fpl_pkg::MPLR_W-1:0]          mpa_q, mpb_q;
  logic signed [fpl_pkg::MCAND_W-1:0]  mca_q, mcb_q;
  logic signed [fpl_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic signed [fpl_pkg::ACC_W-1:0]    ta, tb;

  // MSB of a two's complement multiplier carries negative weight
  always_comb begin
    ta    = mpa_q[fpl_pkg::MPLR_W-1] ? fpl_pkg::ACC_W'(mca_q) : '0;
    tb    = mpb_q[fpl_pkg::MPLR_W-1] ? fpl_pkg::ACC_W'(mcb_q) : '0;
    acc_d = (acc_q <<< 1) + (first_q ? -ta : ta) - (first_q ? -tb : tb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q  <= 1'b1;
        first_q <= 1'b1;
        cnt_q   <= cmd_i.narrow ? fpl_pkg::CNT_W'(fpl_pkg::COEF_BITS)
                                : fpl_pkg::CNT_W'(fpl_pkg::MPLR_W);
      end else if (busy_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q - fpl_pkg::CNT_W'(1);
        if (cnt_q == fpl_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      // short passes left-align the low COEF_BITS of the multiplier
      mpa_q <= cmd_i.narrow ? {mplr_a_i[fpl_pkg::COEF_BITS-1:0], {PadW{1'b0}}} : mplr_a_i;
      mpb_q <= cmd_i.narrow ? {mplr_b_i[fpl_pkg::COEF_BITS-1:0], {PadW{1'b0}}} : mplr_b_i;
      mca_q <= mcand_a_i;
      mcb_q <= mcand_b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      mpa_q <= mpa_q << 1;
      mpb_q <= mpb_q << 1;
      acc_q <= acc_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

endmodule

// ----- rtl/fpl_div6.sv -----
// fpl_div6: bit-serial signed divide by the clipper constant, truncating
// toward zero. Depends on fpl_pkg for widths and the status struct.

module fpl_div6 (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [fpl_pkg::CUBE_W-1:0]   dvd_i,
  output fpl_pkg::unit_stat_t                 stat_o,
  output logic signed [fpl_pkg::CUBE_W-1:0]   quot_o
);

  logic                              busy_q, done_q;
  logic [fpl_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic                              neg_q;
  logic [fpl_pkg::CUBE_W-1:0]        mag_q;   // dividend in, quotient out
  logic [fpl_pkg::REM_W-1:0]         rem_q;
  logic [fpl_pkg::REM_W:0]           rem_ext;
  logic                              ge;

  always_comb begin
    rem_ext = {rem_q, mag_q[fpl_pkg::CUBE_W-1]};
    ge      = (rem_ext >= fpl_pkg::CLIP_DIVISOR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= fpl_pkg::DIV_CNT_W'(fpl_pkg::CUBE_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - fpl_pkg::DIV_CNT_W'(1);
        if (cnt_q == fpl_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dvd_i[fpl_pkg::CUBE_W-1];
      mag_q <= dvd_i[fpl_pkg::CUBE_W-1] ? fpl_pkg::CUBE_W'(-dvd_i) : fpl_pkg::CUBE_W'(dvd_i);
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? fpl_pkg::REM_W'(rem_ext - fpl_pkg::CLIP_DIVISOR)
                  : rem_ext[fpl_pkg::REM_W-1:0];
      mag_q <= {mag_q[fpl_pkg::CUBE_W-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

// ----- rtl/four_pole_ladder_lowpass_core.sv -----
// four_pole_ladder_lowpass_core: four-pole ladder low-pass with cubic clipper.
// Depends on fpl_pkg, fpl_if, fpl_mac and fpl_div6.
//
//  port        dir   width        word / meaning
//  in_ch       sink  16 signed    sample_in, Q1.15 audio word
//  out_ch      src   16 signed    sample_out, Q1.15, rounded and saturated
//  cfg_*       in    2 + 17       coef_p / coef_k / feedback_gain writes
//
// One word at a time: seven passes of the shared bit-serial multiplier (short
// 18-bit passes for feedback and each of the four stages, where p*sum and k*y
// share a pass; full 24-bit passes for each clipper product), a serial divide
// for y^3/6, the output load, then idle. in_ch.ready is high only in idle. A
// finished word waits in the output register while out_ch stalls; the core
// holds in its last state only if the next word is done before that one is
// taken.
// Reset (async, active low) clears the filter state and loads coefficients.

module four_pole_ladder_lowpass_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  fpl_in_if.sink                               in_ch,
  fpl_out_if.source                            out_ch,
  input  logic                                 cfg_we_i,
  input  logic [fpl_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [fpl_pkg::CFG_W-1:0]            cfg_data_i
);

  localparam int unsigned SW = fpl_pkg::STATE_W;
  localparam int unsigned AW = fpl_pkg::ACC_W;

  // Saturation bounds of Q4.20 in accumulator width
  localparam logic signed [AW-1:0] SatHi = AW'(2 ** (SW - 1) - 1);
  localparam logic signed [AW-1:0] SatLo = -AW'(2 ** (SW - 1));
  localparam logic signed [AW-1:0] Rnd14 = AW'(2 ** 13);
  localparam logic signed [AW-1:0] Rnd20 = AW'(2 ** 19);
  localparam int unsigned OutW = SW - 4;  // after the rounding shift by 5, plus sign
  localparam logic signed [OutW-1:0] OutHi = OutW'(2 ** (fpl_pkg::SAMPLE_W - 1) - 1);
  localparam logic signed [OutW-1:0] OutLo = -OutW'(2 ** (fpl_pkg::SAMPLE_W - 1));

  function automatic logic signed [SW-1:0] sat_state(input logic signed [AW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SatHi) begin
      r = SatHi[SW-1:0];
    end else if (v < SatLo) begin
      r = SatLo[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic [fpl_pkg::P_W-1:0]         coef_p_q;
  logic signed [fpl_pkg::K_W-1:0]  coef_k_q;
  logic [fpl_pkg::R_W-1:0]         fb_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_p_q  <= fpl_pkg::COEF_P_RST;
      coef_k_q  <= fpl_pkg::COEF_K_RST;
      fb_gain_q <= fpl_pkg::FB_GAIN_RST;
    end else if (cfg_we_i) begin
      case (fpl_pkg::cfg_idx_e'(cfg_idx_i))
        fpl_pkg::CFG_COEF_P:  coef_p_q  <= cfg_data_i[fpl_pkg::P_W-1:0];
        fpl_pkg::CFG_COEF_K:  coef_k_q  <= $signed(cfg_data_i[fpl_pkg::K_W-1:0]);
        fpl_pkg::CFG_FB_GAIN: fb_gain_q <= cfg_data_i[fpl_pkg::R_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  fpl_pkg::seq_state_e state_q, state_d;

  logic signed [SW-1:0]                   s_q    [4];  // stage outputs
  logic signed [SW-1:0]                   prev_q [4];  // previous stage inputs
  logic [1:0]                             idx_q;       // stage being worked
  logic signed [SW-1:0]                   cur_q;       // input of current stage
  logic signed [fpl_pkg::SAMPLE_W-1:0]    sample_q;
  logic signed [fpl_pkg::SQ_W-1:0]        sq_q;
  logic signed [fpl_pkg::CUBE_W-1:0]      cube_q;
  logic                                   out_valid_q;
  logic signed [fpl_pkg::SAMPLE_W-1:0]    out_data_q;

  // ---------------------------------------------------------------- units
  fpl_pkg::mac_cmd_t                      mac_cmd;
  fpl_pkg::unit_stat_t                    mac_st, div_st;
  logic signed [fpl_pkg::MPLR_W-1:0]      mplr_a, mplr_b;
  logic signed [fpl_pkg::MCAND_W-1:0]     mcand_a, mcand_b;
  logic signed [AW-1:0]                   prod;
  logic                                   div_start;
  logic signed [fpl_pkg::CUBE_W-1:0]      div_quot;
  logic signed [SW:0]                     stg_sum;
  logic                                   out_load;

  fpl_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (mac_cmd),
    .mplr_a_i  (mplr_a),
    .mcand_a_i (mcand_a),
    .mplr_b_i  (mplr_b),
    .mcand_b_i (mcand_b),
    .stat_o    (mac_st),
    .prod_o    (prod)
  );

  fpl_div6 u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (cube_q),
    .stat_o  (div_st),
    .quot_o  (div_quot)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      fpl_pkg::ST_IDLE:     if (in_ch.valid) state_d = fpl_pkg::ST_FEED_GO;
      fpl_pkg::ST_FEED_GO:  state_d = fpl_pkg::ST_FEED_RUN;
      fpl_pkg::ST_FEED_RUN: if (mac_st.done) state_d = fpl_pkg::ST_STG_GO;
      fpl_pkg::ST_STG_GO:   state_d = fpl_pkg::ST_STG_RUN;
      fpl_pkg::ST_STG_RUN: begin
        if (mac_st.done) begin
          state_d = (idx_q == 2'd3) ? fpl_pkg::ST_SQ_GO : fpl_pkg::ST_STG_GO;
        end
      end
      fpl_pkg::ST_SQ_GO:    state_d = fpl_pkg::ST_SQ_RUN;
      fpl_pkg::ST_SQ_RUN:   if (mac_st.done) state_d = fpl_pkg::ST_CUBE_GO;
      fpl_pkg::ST_CUBE_GO:  state_d = fpl_pkg::ST_CUBE_RUN;
      fpl_pkg::ST_CUBE_RUN: if (mac_st.done) state_d = fpl_pkg::ST_DIV_GO;
      fpl_pkg::ST_DIV_GO:   state_d = fpl_pkg::ST_DIV_RUN;
      fpl_pkg::ST_DIV_RUN:  if (div_st.done) state_d = fpl_pkg::ST_FINISH;
      fpl_pkg::ST_FINISH:   if (!out_valid_q || out_ch.ready) state_d = fpl_pkg::ST_IDLE;
      default:              state_d = fpl_pkg::ST_IDLE;
    endcase
  end

  // Operand steering for the shared multiplier, plus divider start and output load
  always_comb begin
    mac_cmd.start  = state_q inside {fpl_pkg::ST_FEED_GO, fpl_pkg::ST_STG_GO,
                                     fpl_pkg::ST_SQ_GO, fpl_pkg::ST_CUBE_GO};
    mac_cmd.narrow = state_q inside {fpl_pkg::ST_FEED_GO, fpl_pkg::ST_STG_GO};
    div_start      = (state_q == fpl_pkg::ST_DIV_GO);
    out_load       = (state_q == fpl_pkg::ST_FINISH) && (!out_valid_q || out_ch.ready);
    stg_sum        = (SW + 1)'(cur_q) + (SW + 1)'(prev_q[idx_q]);
    mplr_a  = '0;
    mcand_a = '0;
    mplr_b  = '0;
    mcand_b = '0;
    case (state_q)
      fpl_pkg::ST_FEED_GO: begin
        // r * y4, resonance feedback
        mplr_a  = fpl_pkg::MPLR_W'($signed({1'b0, fb_gain_q}));
        mcand_a = fpl_pkg::MCAND_W'(s_q[3]);
      end
      fpl_pkg::ST_STG_GO: begin
        // p*(in + prev in) - k*y
        mplr_a  = fpl_pkg::MPLR_W'($signed({1'b0, coef_p_q}));
        mcand_a = fpl_pkg::MCAND_W'(stg_sum);
        mplr_b  = fpl_pkg::MPLR_W'(coef_k_q);
        mcand_b = fpl_pkg::MCAND_W'(s_q[idx_q]);
      end
      fpl_pkg::ST_SQ_GO: begin
        mplr_a  = s_q[3];
        mcand_a = fpl_pkg::MCAND_W'(s_q[3]);
      end
      fpl_pkg::ST_CUBE_GO: begin
        mplr_a  = s_q[3];
        mcand_a = sq_q;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  logic signed [AW-1:0]               rnd14, rnd20, x_wide, clip_wide;
  logic signed [SW-1:0]               x_new, y_new, clip_new;
  logic signed [SW:0]                 out_sum;
  logic signed [OutW-1:0]             out_rnd;
  logic signed [fpl_pkg::SAMPLE_W-1:0] out_sat;

  always_comb begin
    rnd14     = (prod + Rnd14) >>> 14;
    rnd20     = (prod + Rnd20) >>> 20;
    x_wide    = (AW'(sample_q) <<< 5) - rnd14;
    x_new     = sat_state(x_wide);
    y_new     = sat_state(rnd14);
    clip_wide = AW'(s_q[3]) - AW'(div_quot);
    clip_new  = sat_state(clip_wide);
    out_sum   = (SW + 1)'(s_q[3]) + (SW + 1)'(16);
    out_rnd   = OutW'(out_sum >>> 5);
    if (out_rnd > OutHi) begin
      out_sat = OutHi[fpl_pkg::SAMPLE_W-1:0];
    end else if (out_rnd < OutLo) begin
      out_sat = OutLo[fpl_pkg::SAMPLE_W-1:0];
    end else begin
      out_sat = out_rnd[fpl_pkg::SAMPLE_W-1:0];
    end
  end

  // Control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpl_pkg::ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        s_q[i]    <= '0;
        prev_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == fpl_pkg::ST_STG_GO) begin
        prev_q[idx_q] <= cur_q;  // sum already taken by the multiplier
      end
      if (state_q == fpl_pkg::ST_STG_RUN && mac_st.done) begin
        s_q[idx_q] <= y_new;
        idx_q      <= idx_q + 2'd1;
      end
      if (state_q == fpl_pkg::ST_DIV_RUN && div_st.done) begin
        s_q[3] <= clip_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      sample_q <= in_ch.sample_in;
    end
    if (state_q == fpl_pkg::ST_FEED_RUN && mac_st.done) begin
      cur_q <= x_new;
    end
    if (state_q == fpl_pkg::ST_STG_RUN && mac_st.done) begin
      cur_q <= y_new;
    end
    if (state_q == fpl_pkg::ST_SQ_RUN && mac_st.done) begin
      sq_q <= rnd20[fpl_pkg::SQ_W-1:0];
    end
    if (state_q == fpl_pkg::ST_CUBE_RUN && mac_st.done) begin
      cube_q <= rnd20[fpl_pkg::CUBE_W-1:0];
    end
    if (out_load) begin
      out_data_q <= out_sat;
    end
  end

  assign in_ch.ready       = (state_q == fpl_pkg::ST_IDLE);
  assign out_ch.valid      = out_valid_q;
  assign out_ch.sample_out = out_data_q;

  // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
  // a new word never lands while the multiplier or divider is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.ready |-> !mac_st.busy && !div_st.busy)
    else $error("input taken while arithmetic busy");

  // one word in flight: after acceptance the input side closes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second word accepted during processing");

  // a result only appears out of the final sequencer state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_ch.valid) |-> $past(state_q == fpl_pkg::ST_FINISH))
    else $error("output valid raised outside finish");

  // the two serial units never finish together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mac_st.done && div_st.done))
    else $error("multiplier and divider done together");
`endif

endmodule
